>>> sv/assert_macros.svh
// Assertion macros shared by the averager RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// cond must never hold outside reset
`define WVMA_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed: never");

// ante implies cons in the same cycle
`define WVMA_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// ante implies cons in the next cycle
`define WVMA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define WVMA_ASSERT_NEVER(lbl, clk, rst, cond)
`define WVMA_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define WVMA_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> sv/wvma_pkg.sv
// Shared types and constants of the windowed vector moving average.
package wvma_pkg;

   localparam int LANES = 4;

   // func field of a request item
   localparam logic FUNC_SLIDE  = 1'b0;
   localparam logic FUNC_APPEND = 1'b1;

   // status field of a response item
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_FULL_SLID = 1'b1;

   // classification of one item, passed from front to back
   typedef struct packed {
      logic slide;   // drop oldest entry before adding the new one
      logic status;  // append at full window turned into slide
   } cmd_ctl_type;

endpackage

>>> sv/wvma_if.sv
// Request and response channel interfaces of the averager.
interface wvma_req_if #(
   parameter int SAMPLE_BITS = 32
);
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic signed [SAMPLE_BITS-1:0] sample_x;
   logic signed [SAMPLE_BITS-1:0] sample_y;
   logic signed [SAMPLE_BITS-1:0] sample_z;
   logic signed [SAMPLE_BITS-1:0] sample_w;

   modport source (output valid, func, sample_x, sample_y, sample_z, sample_w,
                   input ready);
   modport sink   (input valid, func, sample_x, sample_y, sample_z, sample_w,
                   output ready);
endinterface

interface wvma_rsp_if #(
   parameter int SAMPLE_BITS = 32,
   parameter int COUNT_BITS  = 7
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] avg_x;
   logic signed [SAMPLE_BITS-1:0] avg_y;
   logic signed [SAMPLE_BITS-1:0] avg_z;
   logic signed [SAMPLE_BITS-1:0] avg_w;
   logic [COUNT_BITS-1:0]         entries;
   logic                          status;

   modport source (output valid, avg_x, avg_y, avg_z, avg_w, entries, status,
                   input ready);
   modport sink   (input valid, avg_x, avg_y, avg_z, avg_w, entries, status,
                   output ready);
endinterface

>>> sv/wvma_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wvma_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 64,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/wvma_fifo.sv
// Two-entry command queue between the front and back sections.
`include "assert_macros.svh"

module wvma_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `WVMA_ASSERT_NEVER(a_no_overflow, clock, reset, push && full)
   `WVMA_ASSERT_NEVER(a_no_underflow, clock, reset, pop && empty)

endmodule

>>> sv/wvma_front.sv
// Front section: accepts items, tracks window occupancy, picks slot and mode.
`include "assert_macros.svh"

module wvma_front #(
   parameter int DEPTH      = 64,
   parameter int PTR_BITS   = 6,
   parameter int COUNT_BITS = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   wvma_req_if.sink                 req_ch,
   input  logic                     push_ready,
   output logic                     push,
   output wvma_pkg::cmd_ctl_type    ctl,
   output logic [PTR_BITS-1:0]      slot,
   output logic [COUNT_BITS-1:0]    count
);

   localparam logic [COUNT_BITS-1:0] DEPTH_C  = COUNT_BITS'(DEPTH);
   localparam logic [COUNT_BITS:0]   DEPTH_W  = (COUNT_BITS+1)'(DEPTH);
   localparam logic [PTR_BITS-1:0]   LAST_PTR = PTR_BITS'(DEPTH - 1);

   logic [COUNT_BITS-1:0] held_count_ff, held_count_in;
   logic [PTR_BITS-1:0]   oldest_ptr_ff, oldest_ptr_in;
   logic                  is_full, is_empty;
   logic [COUNT_BITS:0]   tail_sum, tail_wrap;

   assign req_ch.ready = push_ready;
   assign push         = req_ch.valid && push_ready;

   assign is_full  = (held_count_ff == DEPTH_C);
   assign is_empty = (held_count_ff == '0);

   always_comb begin
      // append past capacity slides; slide on an empty window appends
      if (req_ch.func == wvma_pkg::FUNC_APPEND) begin
         ctl.slide  = is_full;
         ctl.status = is_full;
      end else begin
         ctl.slide  = !is_empty;
         ctl.status = wvma_pkg::STATUS_OK;
      end

      tail_sum  = (COUNT_BITS+1)'(oldest_ptr_ff) + (COUNT_BITS+1)'(held_count_ff);
      tail_wrap = (tail_sum >= DEPTH_W) ? (tail_sum - DEPTH_W) : tail_sum;

      held_count_in = held_count_ff;
      oldest_ptr_in = oldest_ptr_ff;
      if (ctl.slide) begin
         slot  = oldest_ptr_ff;
         count = held_count_ff;
         if (push) begin
            oldest_ptr_in = (oldest_ptr_ff == LAST_PTR) ? '0
                                                        : oldest_ptr_ff + PTR_BITS'(1);
         end
      end else begin
         slot  = tail_wrap[PTR_BITS-1:0];
         count = held_count_ff + COUNT_BITS'(1);
         if (push) begin
            held_count_in = count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= '0;
         oldest_ptr_ff <= '0;
      end else begin
         held_count_ff <= held_count_in;
         oldest_ptr_ff <= oldest_ptr_in;
      end
   end

   `WVMA_ASSERT_NEVER(a_held_in_range, clock, reset, held_count_ff > DEPTH_C)
   `WVMA_ASSERT_IMPLY(a_status_when_full, clock, reset, push && ctl.status, is_full)
   `WVMA_ASSERT_NEXT(a_append_grows, clock, reset, push && !ctl.slide, held_count_ff == $past(held_count_ff) + 1)

endmodule

>>> sv/wvma_back.sv
// Back section: ring store update, running sums and bit-serial lane division.
`include "assert_macros.svh"

module wvma_back #(
   parameter int SAMPLE_BITS = 32,
   parameter int PTR_BITS    = 6,
   parameter int COUNT_BITS  = 7,
   parameter int SUM_BITS    = 38,
   localparam int LANE_BITS  = wvma_pkg::LANES * SAMPLE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop,
   input  wvma_pkg::cmd_ctl_type  cmd_ctl,
   input  logic [PTR_BITS-1:0]    cmd_slot,
   input  logic [COUNT_BITS-1:0]  cmd_count,
   input  logic [LANE_BITS-1:0]   cmd_samples,
   output logic                   ram_wr_en,
   output logic [PTR_BITS-1:0]    ram_wr_addr,
   output logic [LANE_BITS-1:0]   ram_wr_data,
   output logic                   ram_rd_en,
   output logic [PTR_BITS-1:0]    ram_rd_addr,
   input  logic [LANE_BITS-1:0]   ram_rd_data,
   wvma_rsp_if.source             rsp_ch
);

   localparam int LANES    = wvma_pkg::LANES;
   localparam int CNT_BITS = $clog2(SUM_BITS);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_ACCUM  = 5'b00010,
      S_SIGN   = 5'b00100,
      S_DIVIDE = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

   state_type                    state_ff, state_in;
   wvma_pkg::cmd_ctl_type        ctl_ff, ctl_in;
   logic [PTR_BITS-1:0]          slot_ff, slot_in;
   logic [COUNT_BITS-1:0]        count_ff, count_in;
   logic [LANE_BITS-1:0]         samples_ff, samples_in;
   logic signed [SUM_BITS-1:0]   sum_ff [LANES];
   logic signed [SUM_BITS-1:0]   sum_in [LANES];
   logic [SUM_BITS-1:0]          mag_ff [LANES];
   logic [SUM_BITS-1:0]          mag_in [LANES];
   logic [COUNT_BITS-1:0]        rem_ff [LANES];
   logic [COUNT_BITS-1:0]        rem_in [LANES];
   logic [LANES-1:0]             neg_ff, neg_in;
   logic [CNT_BITS-1:0]          bit_cnt_ff, bit_cnt_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] avg_ff [LANES];
   logic signed [SAMPLE_BITS-1:0] avg_in [LANES];
   logic [COUNT_BITS-1:0]        entries_ff, entries_in;
   logic                         status_ff, status_in;

   logic signed [SAMPLE_BITS-1:0] new_lane [LANES];
   logic signed [SAMPLE_BITS-1:0] old_lane [LANES];
   logic [COUNT_BITS:0]           trial [LANES];
   logic [SUM_BITS-1:0]           neg_mag [LANES];
   logic                          out_free;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in     = state_ff;
      ctl_in       = ctl_ff;
      slot_in      = slot_ff;
      count_in     = count_ff;
      samples_in   = samples_ff;
      sum_in       = sum_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      bit_cnt_in   = bit_cnt_ff;
      avg_in       = avg_ff;
      entries_in   = entries_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      pop          = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = cmd_slot;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = slot_ff;
      ram_wr_data  = samples_ff;

      for (int i = 0; i < LANES; i++) begin
         new_lane[i] = signed'(samples_ff[i*SAMPLE_BITS +: SAMPLE_BITS]);
         old_lane[i] = signed'(ram_rd_data[i*SAMPLE_BITS +: SAMPLE_BITS]);
         trial[i]    = {rem_ff[i], mag_ff[i][SUM_BITS-1]};
         neg_mag[i]  = -mag_ff[i];
      end

      case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               // read the entry a slide will drop; data is ready in S_ACCUM
               pop        = 1'b1;
               ram_rd_en  = 1'b1;
               ctl_in     = cmd_ctl;
               slot_in    = cmd_slot;
               count_in   = cmd_count;
               samples_in = cmd_samples;
               state_in   = S_ACCUM;
            end
         end
         S_ACCUM: begin
            ram_wr_en = 1'b1;
            for (int i = 0; i < LANES; i++) begin
               if (ctl_ff.slide) begin
                  sum_in[i] = sum_ff[i] + SUM_BITS'(new_lane[i]) - SUM_BITS'(old_lane[i]);
               end else begin
                  sum_in[i] = sum_ff[i] + SUM_BITS'(new_lane[i]);
               end
            end
            state_in = S_SIGN;
         end
         S_SIGN: begin
            for (int i = 0; i < LANES; i++) begin
               neg_in[i] = sum_ff[i][SUM_BITS-1];
               mag_in[i] = sum_ff[i][SUM_BITS-1] ? SUM_BITS'(-sum_ff[i])
                                                 : SUM_BITS'(sum_ff[i]);
               rem_in[i] = '0;
            end
            bit_cnt_in = CNT_BITS'(SUM_BITS - 1);
            state_in   = S_DIVIDE;
         end
         S_DIVIDE: begin
            // restoring division, one quotient bit per lane each cycle;
            // quotient bits shift in as dividend bits shift out
            for (int i = 0; i < LANES; i++) begin
               if (trial[i] >= {1'b0, count_ff}) begin
                  rem_in[i] = COUNT_BITS'(trial[i] - {1'b0, count_ff});
                  mag_in[i] = {mag_ff[i][SUM_BITS-2:0], 1'b1};
               end else begin
                  rem_in[i] = trial[i][COUNT_BITS-1:0];
                  mag_in[i] = {mag_ff[i][SUM_BITS-2:0], 1'b0};
               end
            end
            if (bit_cnt_ff == '0) begin
               state_in = S_DONE;
            end else begin
               bit_cnt_in = bit_cnt_ff - CNT_BITS'(1);
            end
         end
         S_DONE: begin
            if (out_free) begin
               for (int i = 0; i < LANES; i++) begin
                  avg_in[i] = neg_ff[i] ? signed'(neg_mag[i][SAMPLE_BITS-1:0])
                                        : signed'(mag_ff[i][SAMPLE_BITS-1:0]);
               end
               entries_in   = count_ff;
               status_in    = ctl_ff.status;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LANES; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      ctl_ff     <= ctl_in;
      slot_ff    <= slot_in;
      count_ff   <= count_in;
      samples_ff <= samples_in;
      mag_ff     <= mag_in;
      rem_ff     <= rem_in;
      neg_ff     <= neg_in;
      bit_cnt_ff <= bit_cnt_in;
      avg_ff     <= avg_in;
      entries_ff <= entries_in;
      status_ff  <= status_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.avg_x   = avg_ff[0];
   assign rsp_ch.avg_y   = avg_ff[1];
   assign rsp_ch.avg_z   = avg_ff[2];
   assign rsp_ch.avg_w   = avg_ff[3];
   assign rsp_ch.entries = entries_ff;
   assign rsp_ch.status  = status_ff;

   `WVMA_ASSERT_IMPLY(a_divisor_nonzero, clock, reset, state_ff == S_DIVIDE, count_ff != '0)

endmodule

>>> sv/windowed_vector_moving_average.sv
// Top level of the four-lane windowed moving average.
//
//   channel   dir  payload                                      handshake
//   req_ch    in   func, sample_x/y/z/w                         valid/ready
//   rsp_ch    out  avg_x/y/z/w, entries, status                 valid/ready
//
// In the back section an item passes through store read, sum update, sign
// split, then one quotient bit per cycle in the four lane dividers, then the
// output register load.
// Reset is synchronous; it clears window count, pointer, sums and the queue.
// The ring store is not cleared: only data from written entries is ever used.
// A two-item queue lets the front keep accepting while the back divides; a
// stalled response holds the back section with its finished result.
module windowed_vector_moving_average #(
   parameter int DEPTH       = 64,
   parameter int SAMPLE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   wvma_req_if.sink    req_ch,
   wvma_rsp_if.source  rsp_ch
);

   localparam int LANES      = wvma_pkg::LANES;
   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);
   localparam int SUM_BITS   = SAMPLE_BITS + $clog2(DEPTH);
   localparam int LANE_BITS  = LANES * SAMPLE_BITS;
   localparam int CTL_BITS   = $bits(wvma_pkg::cmd_ctl_type);
   localparam int CMD_BITS   = CTL_BITS + PTR_BITS + COUNT_BITS + LANE_BITS;

   logic                   push, fifo_full, fifo_empty, pop;
   wvma_pkg::cmd_ctl_type  front_ctl, back_ctl;
   logic [PTR_BITS-1:0]    front_slot, back_slot;
   logic [COUNT_BITS-1:0]  front_count, back_count;
   logic [LANE_BITS-1:0]   front_samples, back_samples;
   logic [CMD_BITS-1:0]    cmd_wr, cmd_rd;

   logic                   ram_wr_en, ram_rd_en;
   logic [PTR_BITS-1:0]    ram_wr_addr, ram_rd_addr;
   logic [LANE_BITS-1:0]   ram_wr_data, ram_rd_data;

   wvma_front #(
      .DEPTH      (DEPTH),
      .PTR_BITS   (PTR_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_ready (!fifo_full),
      .push       (push),
      .ctl        (front_ctl),
      .slot       (front_slot),
      .count      (front_count)
   );

   assign front_samples = {req_ch.sample_w, req_ch.sample_z,
                           req_ch.sample_y, req_ch.sample_x};
   assign cmd_wr = {front_ctl, front_slot, front_count, front_samples};

   wvma_fifo #(
      .WIDTH (CMD_BITS)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (cmd_wr),
      .full    (fifo_full),
      .pop     (pop),
      .rd_data (cmd_rd),
      .empty   (fifo_empty)
   );

   assign back_ctl     = wvma_pkg::cmd_ctl_type'(cmd_rd[CMD_BITS-1 -: CTL_BITS]);
   assign back_slot    = cmd_rd[LANE_BITS+COUNT_BITS +: PTR_BITS];
   assign back_count   = cmd_rd[LANE_BITS +: COUNT_BITS];
   assign back_samples = cmd_rd[LANE_BITS-1:0];

   wvma_ram #(
      .WIDTH (LANE_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   wvma_back #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .PTR_BITS    (PTR_BITS),
      .COUNT_BITS  (COUNT_BITS),
      .SUM_BITS    (SUM_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (!fifo_empty),
      .pop         (pop),
      .cmd_ctl     (back_ctl),
      .cmd_slot    (back_slot),
      .cmd_count   (back_count),
      .cmd_samples (back_samples),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_ch      (rsp_ch)
   );

endmodule
